@@ design/ssi_pkg.sv @@
package ssi_pkg;

  localparam int CoordWidth  = 16;
  localparam int RadiusWidth = CoordWidth - 1;
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int ProdWidth   = 2 * DiffWidth;
  localparam int AWidth      = ProdWidth;
  localparam int HWidth      = ProdWidth + 2;
  localparam int CrossWidth  = ProdWidth + 1;
  localparam int R2Width     = 2 * RadiusWidth;
  localparam int SplitWidth  = AWidth / 2;
  localparam int ArPartWidth = SplitWidth + R2Width;
  localparam int CmWidth     = 32;
  localparam int DWidth      = 2 * CmWidth;
  localparam int RootWidth   = DWidth / 2;
  localparam int RemWidth    = RootWidth + 2;
  localparam int NumWidth    = HWidth + 1;
  localparam int DivRemWidth = AWidth + 1;
  localparam int TFracBits   = 16;
  localparam int TWidth      = TFracBits + 1;

  typedef struct packed {
    logic                      v;
    logic                      miss;
    logic signed [HWidth-1:0]  h;
    logic        [AWidth-1:0]  a;
  } sq_side_t;

  typedef struct packed {
    logic v;
    logic hit;
    logic far;
  } dv_side_t;

endpackage

@@ design/ssi_if.sv @@
interface ssi_req_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ssi_pkg::CoordWidth-1:0]     start_x;
  logic signed [ssi_pkg::CoordWidth-1:0]     start_y;
  logic signed [ssi_pkg::CoordWidth-1:0]     start_z;
  logic signed [ssi_pkg::CoordWidth-1:0]     end_x;
  logic signed [ssi_pkg::CoordWidth-1:0]     end_y;
  logic signed [ssi_pkg::CoordWidth-1:0]     end_z;
  logic signed [ssi_pkg::CoordWidth-1:0]     center_x;
  logic signed [ssi_pkg::CoordWidth-1:0]     center_y;
  logic signed [ssi_pkg::CoordWidth-1:0]     center_z;
  logic        [ssi_pkg::RadiusWidth-1:0]    radius;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  center_x, center_y, center_z, radius, output ready);
endinterface

interface ssi_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [ssi_pkg::TWidth-1:0]      t_param;
  logic                            far_root;

  modport source (output valid, hit, t_param, far_root, input ready);
  modport sink   (input valid, hit, t_param, far_root, output ready);
endinterface

@@ design/ssi_sqrt_cell.sv @@
module ssi_sqrt_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  ssi_pkg::sq_side_t                side_in,
  input  logic [ssi_pkg::RemWidth-1:0]     rem_in,
  input  logic [ssi_pkg::RootWidth-1:0]    root_in,
  input  logic [ssi_pkg::DWidth-1:0]       d_in,
  output ssi_pkg::sq_side_t                side_out,
  output logic [ssi_pkg::RemWidth-1:0]     rem_out,
  output logic [ssi_pkg::RootWidth-1:0]    root_out,
  output logic [ssi_pkg::DWidth-1:0]       d_out
);

  logic [ssi_pkg::RemWidth+1:0] shifted;
  logic [ssi_pkg::RemWidth+1:0] trial;
  logic [ssi_pkg::RemWidth+1:0] diff;
  logic                         take;

  always_comb begin
    shifted = {rem_in, d_in[ssi_pkg::DWidth-1 -: 2]};
    trial   = {2'b00, root_in, 2'b01};
    take    = shifted >= trial;
    diff    = take ? shifted - trial : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.v <= 1'b0;
    end else if (en) begin
      side_out.v <= side_in.v;
    end
    if (en) begin
      side_out.miss <= side_in.miss;
      side_out.h    <= side_in.h;
      side_out.a    <= side_in.a;
      rem_out       <= diff[ssi_pkg::RemWidth-1:0];
      root_out      <= {root_in[ssi_pkg::RootWidth-2:0], take};
      d_out         <= {d_in[ssi_pkg::DWidth-3:0], 2'b00};
    end
  end

endmodule

@@ design/ssi_div_cell.sv @@
module ssi_div_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  ssi_pkg::dv_side_t                  side_in,
  input  logic [ssi_pkg::DivRemWidth-1:0]    rem_in,
  input  logic [ssi_pkg::AWidth-1:0]         a_in,
  input  logic [ssi_pkg::TWidth-1:0]         quo_in,
  output ssi_pkg::dv_side_t                  side_out,
  output logic [ssi_pkg::DivRemWidth-1:0]    rem_out,
  output logic [ssi_pkg::AWidth-1:0]         a_out,
  output logic [ssi_pkg::TWidth-1:0]         quo_out
);

  logic                               take;
  logic [ssi_pkg::DivRemWidth-1:0]    diff;

  always_comb begin
    take = rem_in >= {1'b0, a_in};
    diff = take ? rem_in - {1'b0, a_in} : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.v <= 1'b0;
    end else if (en) begin
      side_out.v <= side_in.v;
    end
    if (en) begin
      side_out.hit <= side_in.hit;
      side_out.far <= side_in.far;
      rem_out      <= {diff[ssi_pkg::DivRemWidth-2:0], 1'b0};
      a_out        <= a_in;
      quo_out      <= {quo_in[ssi_pkg::TWidth-2:0], take};
    end
  end

endmodule

@@ design/segment_sphere_intersection.sv @@
// Segment against sphere hit test, one request in, one result out.
// The req channel carries the segment start and end points, the sphere
// center and the radius; coordinates are Q8.8, the radius unsigned Q7.8.
// The rsp channel returns hit, the segment parameter t_param in Q1.16 and
// far_root, which tells whether the farther root was used. Both channels use
// a valid/ready handshake. The block takes one request per cycle while
// req.ready is high. A result passes through six arithmetic stages, a chain
// of 32 square root cells that each settle one root bit, one root selection
// stage, a chain of 17 divider cells that each settle one bit of t_param,
// and the output register. Results leave in request order. If the receiver
// stalls while an item reaches the end of the divider chain, a one-entry skid
// register catches it; the whole pipeline holds and req.ready is low while
// it is full. Synchronous reset empties the pipeline; the block keeps no
// other state and takes requests in the first cycle after reset.
module segment_sphere_intersection (
  input logic       clk,
  input logic       rst,
  ssi_req_if.sink   req,
  ssi_rsp_if.source rsp
);

  localparam int SqCells = ssi_pkg::RootWidth;
  localparam int DvCells = ssi_pkg::TWidth;

  logic en;
  logic sv;

  logic signed [ssi_pkg::DiffWidth-1:0]   x1 [3];
  logic signed [ssi_pkg::DiffWidth-1:0]   y1 [3];
  logic        [ssi_pkg::RadiusWidth-1:0] r1;
  logic                                   v1;

  logic signed [ssi_pkg::ProdWidth-1:0]   yy2 [3];
  logic signed [ssi_pkg::ProdWidth-1:0]   xy2 [3];
  logic signed [ssi_pkg::ProdWidth-1:0]   cp2 [6];
  logic        [ssi_pkg::R2Width-1:0]     rr2;
  logic                                   v2;

  logic        [ssi_pkg::AWidth-1:0]      a3;
  logic signed [ssi_pkg::HWidth-1:0]      h3;
  logic        [ssi_pkg::CmWidth-1:0]     cm3 [3];
  logic                                   sat3;
  logic        [ssi_pkg::R2Width-1:0]     rr3;
  logic                                   v3;

  logic        [ssi_pkg::AWidth-1:0]      a4;
  logic signed [ssi_pkg::HWidth-1:0]      h4;
  logic        [ssi_pkg::DWidth-1:0]      sq4 [3];
  logic        [ssi_pkg::ArPartWidth-1:0] arlo4;
  logic        [ssi_pkg::ArPartWidth-1:0] arhi4;
  logic                                   sat4;
  logic                                   v4;

  logic        [ssi_pkg::AWidth-1:0]      a5;
  logic signed [ssi_pkg::HWidth-1:0]      h5;
  logic        [ssi_pkg::DWidth+1:0]      cr5;
  logic        [ssi_pkg::DWidth-1:0]      ar5;
  logic                                   sat5;
  logic                                   v5;

  logic signed [ssi_pkg::CrossWidth-1:0]  c_comb [3];
  logic        [ssi_pkg::CrossWidth-1:0]  cabs   [3];

  ssi_pkg::sq_side_t                 sq_side [SqCells+1];
  logic [ssi_pkg::RemWidth-1:0]      sq_rem  [SqCells+1];
  logic [ssi_pkg::RootWidth-1:0]     sq_root [SqCells+1];
  logic [ssi_pkg::DWidth-1:0]        sq_d    [SqCells+1];

  ssi_pkg::dv_side_t                 dv_side [DvCells+1];
  logic [ssi_pkg::DivRemWidth-1:0]   dv_rem  [DvCells+1];
  logic [ssi_pkg::AWidth-1:0]        dv_a    [DvCells+1];
  logic [ssi_pkg::TWidth-1:0]        dv_quo  [DvCells+1];

  logic signed [ssi_pkg::NumWidth-1:0] n_near;
  logic signed [ssi_pkg::NumWidth-1:0] n_far;
  logic signed [ssi_pkg::NumWidth-1:0] a_ext;
  logic                                ok_near;
  logic                                ok_far;

  logic                         ov;
  logic                         o_hit;
  logic                         o_far;
  logic [ssi_pkg::TWidth-1:0]   o_t;
  logic                         s_hit;
  logic                         s_far;
  logic [ssi_pkg::TWidth-1:0]   s_t;
  logic                         tail_v;
  logic                         tail_hit;
  logic                         tail_far;
  logic [ssi_pkg::TWidth-1:0]   tail_t;

  assign en        = !sv;
  assign req.ready = en;

  // Front arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    c_comb[0] = ssi_pkg::CrossWidth'(cp2[0]) - ssi_pkg::CrossWidth'(cp2[1]);
    c_comb[1] = ssi_pkg::CrossWidth'(cp2[2]) - ssi_pkg::CrossWidth'(cp2[3]);
    c_comb[2] = ssi_pkg::CrossWidth'(cp2[4]) - ssi_pkg::CrossWidth'(cp2[5]);
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c_comb[i][ssi_pkg::CrossWidth-1] ? -c_comb[i] : c_comb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1[0] <= ssi_pkg::DiffWidth'(req.start_x) - ssi_pkg::DiffWidth'(req.center_x);
      x1[1] <= ssi_pkg::DiffWidth'(req.start_y) - ssi_pkg::DiffWidth'(req.center_y);
      x1[2] <= ssi_pkg::DiffWidth'(req.start_z) - ssi_pkg::DiffWidth'(req.center_z);
      y1[0] <= ssi_pkg::DiffWidth'(req.end_x) - ssi_pkg::DiffWidth'(req.start_x);
      y1[1] <= ssi_pkg::DiffWidth'(req.end_y) - ssi_pkg::DiffWidth'(req.start_y);
      y1[2] <= ssi_pkg::DiffWidth'(req.end_z) - ssi_pkg::DiffWidth'(req.start_z);
      r1    <= req.radius;

      for (int i = 0; i < 3; i++) begin
        yy2[i] <= y1[i] * y1[i];
        xy2[i] <= x1[i] * y1[i];
      end
      cp2[0] <= x1[1] * y1[2];
      cp2[1] <= x1[2] * y1[1];
      cp2[2] <= x1[2] * y1[0];
      cp2[3] <= x1[0] * y1[2];
      cp2[4] <= x1[0] * y1[1];
      cp2[5] <= x1[1] * y1[0];
      rr2    <= r1 * r1;

      a3   <= ssi_pkg::AWidth'(yy2[0]) + ssi_pkg::AWidth'(yy2[1]) + ssi_pkg::AWidth'(yy2[2]);
      h3   <= ssi_pkg::HWidth'(xy2[0]) + ssi_pkg::HWidth'(xy2[1]) + ssi_pkg::HWidth'(xy2[2]);
      sat3 <= (cabs[0][ssi_pkg::CrossWidth-1:ssi_pkg::CmWidth] != '0) ||
              (cabs[1][ssi_pkg::CrossWidth-1:ssi_pkg::CmWidth] != '0) ||
              (cabs[2][ssi_pkg::CrossWidth-1:ssi_pkg::CmWidth] != '0);
      for (int i = 0; i < 3; i++) begin
        cm3[i] <= cabs[i][ssi_pkg::CmWidth-1:0];
      end
      rr3 <= rr2;

      a4 <= a3;
      h4 <= h3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= cm3[i] * cm3[i];
      end
      arlo4 <= a3[ssi_pkg::SplitWidth-1:0] * rr3;
      arhi4 <= a3[ssi_pkg::AWidth-1:ssi_pkg::SplitWidth] * rr3;
      sat4  <= sat3;

      a5   <= a4;
      h5   <= h4;
      cr5  <= (ssi_pkg::DWidth+2)'(sq4[0]) + (ssi_pkg::DWidth+2)'(sq4[1]) +
              (ssi_pkg::DWidth+2)'(sq4[2]);
      ar5  <= ssi_pkg::DWidth'({arhi4, {ssi_pkg::SplitWidth{1'b0}}}) +
              ssi_pkg::DWidth'(arlo4);
      sat5 <= sat4;
    end
  end

  // Discriminant stage feeding the square root chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].v <= 1'b0;
    end else if (en) begin
      sq_side[0].v <= v5;
    end
    if (en) begin
      sq_side[0].miss <= sat5 || (a5 == '0) || (cr5 > {2'b00, ar5});
      sq_side[0].h    <= h5;
      sq_side[0].a    <= a5;
      sq_rem[0]       <= '0;
      sq_root[0]      <= '0;
      sq_d[0]         <= ar5 - cr5[ssi_pkg::DWidth-1:0];
    end
  end

  for (genvar g = 0; g < SqCells; g++) begin : g_sqrt
    ssi_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (sq_side[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .d_in     (sq_d[g]),
      .side_out (sq_side[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .d_out    (sq_d[g+1])
    );
  end

  // Root selection.
  always_comb begin
    n_near  = -ssi_pkg::NumWidth'(sq_side[SqCells].h) -
              $signed(ssi_pkg::NumWidth'(sq_root[SqCells]));
    n_far   = -ssi_pkg::NumWidth'(sq_side[SqCells].h) +
              $signed(ssi_pkg::NumWidth'(sq_root[SqCells]));
    a_ext   = $signed(ssi_pkg::NumWidth'(sq_side[SqCells].a));
    ok_near = !sq_side[SqCells].miss && !n_near[ssi_pkg::NumWidth-1] && (n_near <= a_ext);
    ok_far  = !sq_side[SqCells].miss && !n_far[ssi_pkg::NumWidth-1] && (n_far <= a_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_side[0].v <= 1'b0;
    end else if (en) begin
      dv_side[0].v <= sq_side[SqCells].v;
    end
    if (en) begin
      dv_side[0].hit <= ok_near || ok_far;
      dv_side[0].far <= !ok_near && ok_far;
      dv_rem[0]      <= ok_near ? n_near[ssi_pkg::DivRemWidth-1:0]
                                : n_far[ssi_pkg::DivRemWidth-1:0];
      dv_a[0]        <= sq_side[SqCells].a;
      dv_quo[0]      <= '0;
    end
  end

  for (genvar g = 0; g < DvCells; g++) begin : g_div
    ssi_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (dv_side[g]),
      .rem_in   (dv_rem[g]),
      .a_in     (dv_a[g]),
      .quo_in   (dv_quo[g]),
      .side_out (dv_side[g+1]),
      .rem_out  (dv_rem[g+1]),
      .a_out    (dv_a[g+1]),
      .quo_out  (dv_quo[g+1])
    );
  end

  assign tail_v   = dv_side[DvCells].v;
  assign tail_hit = dv_side[DvCells].hit;
  assign tail_far = dv_side[DvCells].hit && dv_side[DvCells].far;
  assign tail_t   = dv_side[DvCells].hit ? dv_quo[DvCells] : '0;

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || rsp.ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= en && tail_v;
      end
    end else if (en && tail_v) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || rsp.ready) begin
      if (sv) begin
        o_hit <= s_hit;
        o_far <= s_far;
        o_t   <= s_t;
      end else begin
        o_hit <= tail_hit;
        o_far <= tail_far;
        o_t   <= tail_t;
      end
    end else if (en && tail_v) begin
      s_hit <= tail_hit;
      s_far <= tail_far;
      s_t   <= tail_t;
    end
  end

  assign rsp.valid    = ov;
  assign rsp.hit      = o_hit;
  assign rsp.far_root = o_far;
  assign rsp.t_param  = o_t;

endmodule

@@ sim/tb_segment_sphere_intersection.sv @@
module tb_segment_sphere_intersection;

  typedef struct packed {
    logic signed [ssi_pkg::CoordWidth-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
    logic [ssi_pkg::RadiusWidth-1:0] r;
  } seg_req_t;

  typedef struct packed {
    logic hit;
    logic [ssi_pkg::TWidth-1:0] t;
    logic far;
  } hit_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ssi_req_if req ();
  ssi_rsp_if rsp ();

  segment_sphere_intersection u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hit_rsp_t expected_hits[$];
  int errors = 0;
  int sent = 0;
  int hits_seen = 0;
  int far_seen = 0;
  int checked = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cross_sq(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    if (m >= (64'd1 << 32)) return '1;
    return m * m;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] p, logic [63:0] q);
    logic [63:0] s;
    s = p + q;
    return (s < p) ? '1 : s;
  endfunction

  function automatic hit_rsp_t predict_hit(seg_req_t s);
    longint xv[3], yv[3], a, h, c0, c1, c2, nv[2];
    logic [63:0] rr, ar2, cr, d, sq, tq;
    hit_rsp_t o;
    o = '0;
    xv[0] = longint'(s.sx) - longint'(s.cx);
    xv[1] = longint'(s.sy) - longint'(s.cy);
    xv[2] = longint'(s.sz) - longint'(s.cz);
    yv[0] = longint'(s.ex) - longint'(s.sx);
    yv[1] = longint'(s.ey) - longint'(s.sy);
    yv[2] = longint'(s.ez) - longint'(s.sz);
    rr = {49'd0, s.r};
    a = yv[0] * yv[0] + yv[1] * yv[1] + yv[2] * yv[2];
    h = xv[0] * yv[0] + xv[1] * yv[1] + xv[2] * yv[2];
    if (a == 0) return o;
    c0 = xv[1] * yv[2] - xv[2] * yv[1];
    c1 = xv[2] * yv[0] - xv[0] * yv[2];
    c2 = xv[0] * yv[1] - xv[1] * yv[0];
    cr = sat_add(sat_add(cross_sq(c0), cross_sq(c1)), cross_sq(c2));
    ar2 = 64'(a) * (rr * rr);
    if (cr > ar2) return o;
    d = ar2 - cr;
    sq = floor_sqrt(d);
    nv[0] = -h - longint'(sq);
    nv[1] = -h + longint'(sq);
    for (int i = 0; i < 2; i++) begin
      if (nv[i] >= 0 && nv[i] <= a) begin
        tq = (64'(nv[i]) << ssi_pkg::TFracBits) / 64'(a);
        o.hit = 1'b1;
        o.t = tq[ssi_pkg::TWidth-1:0];
        o.far = (i == 1);
        return o;
      end
    end
    return o;
  endfunction

  task automatic send_segment(seg_req_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.start_x, req.start_y, req.start_z, req.end_x, req.end_y, req.end_z,
     req.center_x, req.center_y, req.center_z, req.radius} <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_hits.push_back(predict_hit(s));
    sent++;
  endtask

  task automatic go_quiet();
    req.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    hit_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b t=%0d far=%0b", $time,
                 rsp.hit, rsp.t_param, rsp.far_root);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        checked++;
        if (want.hit) hits_seen++;
        if (want.far) far_seen++;
        if (rsp.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp.hit);
          errors++;
        end
        if (rsp.t_param !== want.t) begin
          $display("%0t: t_param expected %0d actual %0d", $time, want.t, rsp.t_param);
          errors++;
        end
        if (rsp.far_root !== want.far) begin
          $display("%0t: far_root expected %0b actual %0b", $time, want.far,
                   rsp.far_root);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("segment_sphere_intersection regression: fail");
        $finish;
      end
    end
  end

  function automatic seg_req_t raw_segment();
    logic [159:0] bits;
    seg_req_t s;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    s = bits[$bits(seg_req_t)-1:0];
    return s;
  endfunction

  // Builds a segment around a sphere so that crossings and grazes are common.
  function automatic seg_req_t aimed_segment();
    seg_req_t s;
    int span;
    span = (1 << $urandom_range(14, 4));
    s.cx = 16'($urandom_range(65535));
    s.cy = 16'($urandom_range(65535));
    s.cz = 16'($urandom_range(65535));
    s.r = 15'($urandom_range(span));
    s.sx = 16'(s.cx + $signed($urandom_range(2 * span)) - span);
    s.sy = 16'(s.cy + $signed($urandom_range(2 * span)) - span);
    s.sz = 16'(s.cz + $signed($urandom_range(2 * span)) - span);
    s.ex = 16'(s.cx + $signed($urandom_range(2 * span)) - span);
    s.ey = 16'(s.cy + $signed($urandom_range(2 * span)) - span);
    s.ez = 16'(s.cz + $signed($urandom_range(2 * span)) - span);
    return s;
  endfunction

  task automatic test_directed();
    seg_req_t s;
    s = '0;
    send_segment(s);
    s.r = 15'h7fff;
    send_segment(s);
    s = '{16'sh0000, 0, 0, 16'sh0400, 0, 0, 16'sh0200, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh0200, 0, 0, 16'sh0600, 0, 0, 16'sh0200, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh0000, 0, 0, 16'sh0100, 0, 0, 16'sh0800, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh0000, 16'sh0100, 0, 16'sh0400, 16'sh0100, 0, 16'sh0200, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh0000, 16'sh0200, 0, 16'sh0400, 16'sh0200, 0, 16'sh0200, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh0000, 0, 0, 16'sh0100, 0, 0, 16'sh0000, 0, 0, 15'h0100};
    send_segment(s);
    s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh0000, 0, 0, 15'h7fff};
    send_segment(s);
    s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh8000, 15'h7fff};
    send_segment(s);
    s = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh7fff, 15'h0000};
    send_segment(s);
    s = '{16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234,
          16'sh1234, 16'sh1234, 16'sh1234, 15'h7fff};
    send_segment(s);
    s = '{16'sh0000, 0, 0, 16'sh0001, 0, 0, 16'sh0000, 0, 0, 15'h0001};
    send_segment(s);
    go_quiet();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) send_segment(aimed_segment());
      else send_segment(raw_segment());
    end
    go_quiet();
  endtask

  initial begin
    req.valid = 1'b0;
    {req.start_x, req.start_y, req.start_z, req.end_x, req.end_y, req.end_z,
     req.center_x, req.center_y, req.center_z, req.radius} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 37;
    recv_idle_pct = 45;
    test_random(310);
    send_idle_pct = 45;
    recv_idle_pct = 37;
    test_random(310);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(310);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d segment tests and checked %0d results.", sent, checked);
    $display("Hits: %0d, of which %0d took the farther root.", hits_seen, far_seen);
    if (errors == 0) begin
      $display("segment_sphere_intersection regression: pass");
    end else begin
      $display("segment_sphere_intersection regression: fail");
    end
    $finish;
  end
endmodule
